### sv/utf8_to_utf16_decoder_macros.svh
// assertion macros for the utf-8 to utf-16 decoder
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// consequent must hold in the same cycle
`define U8U16_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("u8u16 same-cycle check failed");

// consequent must hold in the following cycle
`define U8U16_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("u8u16 next-cycle check failed");

`endif

### sv/u8u16_pkg.sv
// shared types, constants and byte classification for the utf-8 to utf-16 decoder
`default_nettype none

package u8u16_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_unit;
    typedef logic [2:0]  t_seq_len;

    localparam t_unit    REPLACEMENT  = 16'hFFFD;
    localparam t_unit    HIGH_BASE    = 16'hD800;
    localparam t_unit    LOW_BASE     = 16'hDC00;
    localparam int       PLANE_OFFSET = 32'h0001_0000;
    localparam t_byte    ASCII_LIMIT  = 8'h80;
    localparam t_byte    TWO_LIMIT    = 8'hE0;
    localparam t_byte    THREE_LIMIT  = 8'hF0;

    localparam t_seq_len LEN_ONE   = 3'd1;
    localparam t_seq_len LEN_TWO   = 3'd2;
    localparam t_seq_len LEN_THREE = 3'd3;
    localparam t_seq_len LEN_FOUR  = 3'd4;

    // sequence length selected by a lead byte
    function automatic t_seq_len class_len(input t_byte b);
        t_seq_len len;
        if (b < ASCII_LIMIT) begin
            len = LEN_ONE;
        end else if (b < TWO_LIMIT) begin
            len = LEN_TWO;
        end else if (b < THREE_LIMIT) begin
            len = LEN_THREE;
        end else begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

### sv/utf8_to_utf16_decoder.sv
// utf-8 byte stream to utf-16 code unit stream decoder
`default_nettype none

// Takes one utf-8 byte per beat (tlast marks the last byte of a string) and gives utf-16
// code units, with tlast on the last unit caused by a byte. Bytes of an open sequence are
// held in up to three registers and the whole sequence is decoded in the cycle its final
// byte arrives, straight into a three-entry result register. A byte is taken every cycle
// while each byte gives at most one unit and the sink takes every beat; a byte that gives
// two or three units (a surrogate pair or a string cut short inside a sequence) keeps
// tready low until only its last unit is left, the register draining one unit a cycle while
// the sink takes them. Results are registered and shown in the cycle after the completing byte.

`include "utf8_to_utf16_decoder_macros.svh"

module utf8_to_utf16_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // string_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] code_unit
    output logic             o_m_tlast    // run_last
);

    u8u16_pkg::t_byte    r_pend [3];
    logic [1:0]          r_held;
    u8u16_pkg::t_seq_len r_seqlen;
    u8u16_pkg::t_unit    r_unit [3];
    logic [1:0]          r_cnt;

    u8u16_pkg::t_unit    n_unit [3];
    logic [1:0]          n_cnt;
    logic [1:0]          n_held;
    u8u16_pkg::t_seq_len n_seqlen;

    logic                w_s_fire;
    logic                w_m_fire;
    logic [2:0]          w_n;
    u8u16_pkg::t_seq_len w_need;
    logic                w_done;
    u8u16_pkg::t_byte    w_buf [4];
    u8u16_pkg::t_unit    w_res [3];
    logic [1:0]          w_nres;
    logic [25:0]         w_cp;
    logic [1:0]          w_tail;

    assign w_m_fire   = r_cnt != 2'd0 && i_m_tready;
    assign o_s_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_tready);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_cnt != 2'd0;
    assign o_m_tdata  = r_unit[0];
    assign o_m_tlast  = r_cnt == 2'd1;

    // assemble held bytes and the new byte
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i < 32'(r_held)) begin
                w_buf[i] = r_pend[i];
            end else begin
                w_buf[i] = i_s_tdata;
            end
        end
    end

    assign w_n    = {1'b0, r_held} + 3'd1;
    assign w_need = (r_held == 2'd0) ? u8u16_pkg::class_len(i_s_tdata) : r_seqlen;
    assign w_done = i_s_tlast || (w_n >= w_need) || (w_n >= 3'd4);
    assign w_tail = r_held;
    assign w_cp   = {5'd0, w_buf[0][2:0], w_buf[1][5:0], w_buf[2][5:0], w_buf[3][5:0]}
                  - 26'(u8u16_pkg::PLANE_OFFSET);

    // decode a finished sequence, or a string cut short inside one
    always_comb begin
        w_res[0] = '0;
        w_res[1] = '0;
        w_res[2] = '0;
        w_nres   = 2'd1;
        if (w_n >= w_need) begin
            case (w_need)
                u8u16_pkg::LEN_ONE: begin
                    w_res[0] = {8'd0, w_buf[0]};
                end
                u8u16_pkg::LEN_TWO: begin
                    w_res[0] = {5'd0, w_buf[0][4:0], w_buf[1][5:0]};
                end
                u8u16_pkg::LEN_THREE: begin
                    w_res[0] = {w_buf[0][3:0], w_buf[1][5:0], w_buf[2][5:0]};
                end
                u8u16_pkg::LEN_FOUR: begin
                    w_res[0] = u8u16_pkg::HIGH_BASE | w_cp[25:10];
                    w_res[1] = u8u16_pkg::LOW_BASE | {6'd0, w_cp[9:0]};
                    w_nres   = 2'd2;
                end
                default: begin
                    w_res[0] = u8u16_pkg::REPLACEMENT;
                end
            endcase
        end else begin
            w_res[0] = u8u16_pkg::REPLACEMENT;
            case (w_tail)
                2'd1: begin
                    w_res[1] = (w_buf[1] < u8u16_pkg::ASCII_LIMIT) ? {8'd0, w_buf[1]}
                                                                    : u8u16_pkg::REPLACEMENT;
                    w_nres   = 2'd2;
                end
                2'd2: begin
                    if (u8u16_pkg::class_len(w_buf[1]) == u8u16_pkg::LEN_TWO) begin
                        w_res[1] = {5'd0, w_buf[1][4:0], w_buf[2][5:0]};
                        w_nres   = 2'd2;
                    end else begin
                        w_res[1] = (w_buf[1] < u8u16_pkg::ASCII_LIMIT) ? {8'd0, w_buf[1]}
                                                                        : u8u16_pkg::REPLACEMENT;
                        w_res[2] = (w_buf[2] < u8u16_pkg::ASCII_LIMIT) ? {8'd0, w_buf[2]}
                                                                        : u8u16_pkg::REPLACEMENT;
                        w_nres   = 2'd3;
                    end
                end
                default: begin
                    w_nres = 2'd1;
                end
            endcase
        end
    end

    // result register: load on a finishing beat, shift down on each output beat
    always_comb begin
        n_unit = r_unit;
        n_cnt  = r_cnt;
        if (w_m_fire) begin
            n_unit[0] = r_unit[1];
            n_unit[1] = r_unit[2];
            n_cnt     = r_cnt - 2'd1;
        end
        if (w_s_fire && w_done) begin
            n_unit = w_res;
            n_cnt  = w_nres;
        end
    end

    always_comb begin
        n_held   = r_held;
        n_seqlen = r_seqlen;
        if (w_s_fire) begin
            if (w_done) begin
                n_held   = 2'd0;
                n_seqlen = u8u16_pkg::LEN_ONE;
            end else begin
                n_held   = w_n[1:0];
                n_seqlen = w_need;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_seqlen <= u8u16_pkg::LEN_ONE;
            r_cnt    <= 2'd0;
        end else begin
            r_held   <= n_held;
            r_seqlen <= n_seqlen;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        if (w_s_fire && !w_done) begin
            r_pend[r_held] <= i_s_tdata;
        end
    end

    // an open sequence always still lacks at least one byte
    `U8U16_ASSERT_SAME(a_held_below_need, r_held != 2'd0, {1'b0, r_held} < r_seqlen)
    // the last byte of a string leaves nothing held
    `U8U16_ASSERT_NEXT(a_end_clears, w_s_fire && i_s_tlast, r_held == 2'd0)
    // a finishing byte always puts at least one unit on the output
    `U8U16_ASSERT_NEXT(a_done_gives_unit, w_s_fire && w_done, o_m_tvalid)

endmodule

`default_nettype wire

### dv/utf8_to_utf16_decoder_checker.sv
// checker for the utf-8 to utf-16 decoder: predicts code units from byte beats and compares
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // string_end
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [15:0] code_unit
    input  logic        i_m_tlast,   // run_last
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        u8u16_pkg::t_unit unit;
        logic             run_last;
    } t_unit_beat;

    t_unit_beat expected_units[$];

    u8u16_pkg::t_byte    held_bytes[3];
    logic [1:0]          held_count;
    u8u16_pkg::t_seq_len open_len;
    u8u16_pkg::t_byte    run_bytes[4];

    function automatic u8u16_pkg::t_seq_len lead_length(input u8u16_pkg::t_byte b);
        casez (b)
            8'b0???_????: return u8u16_pkg::LEN_ONE;
            8'b10??_????: return u8u16_pkg::LEN_TWO;
            8'b110?_????: return u8u16_pkg::LEN_TWO;
            8'b1110_????: return u8u16_pkg::LEN_THREE;
            default:      return u8u16_pkg::LEN_FOUR;
        endcase
    endfunction

    // decode run_bytes[0 .. n-1] as a finished string
    task automatic decode_run(input int n);
        u8u16_pkg::t_unit units[$];
        int               i;
        int               len;
        u8u16_pkg::t_byte b;
        logic [31:0]      cp;
        t_unit_beat       beat;
        i = 0;
        while (i < n) begin
            b = run_bytes[i];
            len = lead_length(b);
            if (i + len - 1 >= n) begin
                units.push_back(u8u16_pkg::REPLACEMENT);
                i = i + 1;
            end else begin
                case (len)
                    1: begin
                        units.push_back({8'h00, b});
                    end
                    2: begin
                        units.push_back({5'b0, b[4:0], run_bytes[i+1][5:0]});
                    end
                    3: begin
                        units.push_back({b[3:0], run_bytes[i+1][5:0],
                                         run_bytes[i+2][5:0]});
                    end
                    default: begin
                        cp = {11'b0, b[2:0], run_bytes[i+1][5:0], run_bytes[i+2][5:0],
                              run_bytes[i+3][5:0]};
                        cp = cp - u8u16_pkg::PLANE_OFFSET;
                        units.push_back(u8u16_pkg::HIGH_BASE | cp[25:10]);
                        units.push_back(u8u16_pkg::LOW_BASE | {6'b0, cp[9:0]});
                    end
                endcase
                i = i + len;
            end
        end
        for (i = 0; i < units.size(); i++) begin
            beat.unit = units[i];
            beat.run_last = (i == units.size() - 1);
            expected_units.push_back(beat);
        end
    endtask

    task automatic predict_byte(input u8u16_pkg::t_byte b, input logic fin);
        int                  i;
        int                  n;
        u8u16_pkg::t_seq_len need;
        for (i = 0; i < held_count; i++) begin
            run_bytes[i] = held_bytes[i];
        end
        run_bytes[held_count] = b;
        n = held_count + 1;
        need = (held_count == 0) ? lead_length(b) : open_len;
        if (fin || n >= need || n >= 4) begin
            decode_run(n);
            held_count = 2'd0;
            open_len = u8u16_pkg::LEN_ONE;
        end else begin
            held_bytes[held_count] = b;
            held_count = n[1:0];
            open_len = need;
        end
    endtask

    task automatic check_unit();
        t_unit_beat want;
        if (expected_units.size() == 0) begin
            $error("code_unit expected none actual %h", i_m_tdata);
            o_fail_count = o_fail_count + 1;
        end else begin
            want = expected_units.pop_front();
            if (i_m_tdata !== want.unit) begin
                $error("code_unit expected %h actual %h", want.unit, i_m_tdata);
                o_fail_count = o_fail_count + 1;
            end
            if (i_m_tlast !== want.run_last) begin
                $error("run_last expected %b actual %b", want.run_last, i_m_tlast);
                o_fail_count = o_fail_count + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 2'd0;
            open_len = u8u16_pkg::LEN_ONE;
            expected_units.delete();
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_unit();
            end
        end
        o_outstanding = expected_units.size();
    end

endmodule

### dv/utf8_to_utf16_decoder_tb.sv
// testbench top for the utf-8 to utf-16 decoder: byte stimulus, sink stalls and verdict
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_tb;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          outstanding;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int bytes_sent = 0;

    // bit 8 marks the string end
    logic [8:0] directed_beats [25] = '{
        9'h000, 9'h17F,
        9'h0C3, 9'h0A9,
        9'h080, 9'h080,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h0F0, 9'h080, 9'h080, 9'h080,
        9'h0F0, 9'h141,
        9'h0E0, 9'h1C3,
        9'h1E5,
        9'h0F0, 9'h0E0, 9'h180
    };

    utf8_to_utf16_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    utf8_to_utf16_decoder_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // called and returns at a falling edge
    task automatic send_beat(input u8u16_pkg::t_byte b, input logic fin);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = gap + 1;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // mostly well-formed characters with random payload, some noise and cut strings
    task automatic send_random_string();
        u8u16_pkg::t_byte q[$];
        int               chars;
        int               kind;
        int               n_send;
        int               i;
        chars = $urandom_range(1, 6);
        repeat (chars) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                q.push_back(u8u16_pkg::t_byte'($urandom_range(0, 127)));
            end else if (kind < 5) begin
                q.push_back(u8u16_pkg::t_byte'(8'hC0 | $urandom_range(0, 31)));
                q.push_back(u8u16_pkg::t_byte'(8'h80 | $urandom_range(0, 63)));
            end else if (kind < 7) begin
                q.push_back(u8u16_pkg::t_byte'(8'hE0 | $urandom_range(0, 15)));
                repeat (2) q.push_back(u8u16_pkg::t_byte'(8'h80 | $urandom_range(0, 63)));
            end else if (kind < 9) begin
                q.push_back(u8u16_pkg::t_byte'(8'hF0 | $urandom_range(0, 15)));
                repeat (3) q.push_back(u8u16_pkg::t_byte'(8'h80 | $urandom_range(0, 63)));
            end else begin
                q.push_back(u8u16_pkg::t_byte'($urandom_range(0, 255)));
            end
        end
        n_send = q.size();
        if ($urandom_range(0, 9) == 0) begin
            n_send = $urandom_range(1, q.size());
        end
        for (i = 0; i < n_send; i++) begin
            send_beat(q[i], i == n_send - 1);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int phase_end;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        phase_end = bytes_sent + n_bytes;
        while (bytes_sent < phase_end) send_random_string();
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_beats[k]) begin
            send_beat(directed_beats[k][7:0], directed_beats[k][8]);
        end
        run_phase(0, 0, 65);
        run_phase(50, 0, 65);
        run_phase(0, 50, 65);
        run_phase(6, 6, 65);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("utf8_to_utf16_decoder regression: pass");
        end else begin
            $display("utf8_to_utf16_decoder regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("utf8_to_utf16_decoder regression: fail");
        $finish;
    end

endmodule
